// ===== hdl/drs_pkg.sv =====
// Shared types and constants for the disk request scheduler.
package drs_pkg;

    localparam int DRS_QUEUE_DEPTH = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BLOCK_SIZE = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0]  IDLE_LIMIT_RST     = 4'd2;
    localparam logic [11:0] BLOCK_COUNT_RST    = 12'd360;
    localparam logic [15:0] MAX_BLOCK_SIZE_RST = 16'd9216;

    // ceil(2^16 / 9): exact quotient for dividends below 4096
    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    localparam logic signed [7:0] OP_READ  = 8'sd1;
    localparam logic signed [7:0] OP_WRITE = 8'sd2;

    typedef enum logic [2:0] {
        KIND_QUEUED     = 3'd0,
        KIND_NOT_QUEUED = 3'd1,
        KIND_IDLE       = 3'd2,
        KIND_SERVED     = 3'd3,
        KIND_REJECTED   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MOTOR_NONE  = 2'd0,
        MOTOR_START = 2'd1,
        MOTOR_STOP  = 2'd2
    } motor_t;

    typedef struct packed {
        logic [7:0]  op;
        logic [15:0] req;
        logic [15:0] blk;
        logic [15:0] bytes;
        logic [31:0] addr;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

    typedef struct packed {
        logic [3:0] err;
        logic [8:0] cylinder;
        logic       track;
        logic [3:0] sector;
    } xlate_t;

endpackage

// ===== hdl/drs_cell.sv =====
// One slot of the sorted pending chain.
module drs_cell
    import drs_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     entry_new,
    input  entry_t     entry_prev,
    input  entry_t     entry_next,
    input  logic       occ_self,
    input  logic       occ_prev,
    input  logic       gt_prev,
    output entry_t     entry,
    output logic       gt
);

    entry_t entry_reg;
    entry_t entry_next_val;

    // Hold a block strictly above the new one: that entry moves one step down.
    assign gt = occ_self && ($signed(entry_reg.blk) > $signed(entry_new.blk));

    always_comb
    begin
        entry_next_val = entry_reg;
        if (ctrl.remove)
        begin
            entry_next_val = entry_next;
        end
        else if (ctrl.insert)
        begin
            if (gt_prev)
            begin
                entry_next_val = entry_prev;
            end
            else if ((gt || !occ_self) && occ_prev)
            begin
                entry_next_val = entry_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next_val;
    end

    assign entry = entry_reg;

endmodule

// ===== hdl/drs_xlate.sv =====
// Request validation and block to cylinder/track/sector translation.
module drs_xlate
    import drs_pkg::*;
(
    input  entry_t      head,
    input  logic [11:0] block_count,
    input  logic [15:0] max_block_size,
    output xlate_t      res
);

    logic [11:0] b;
    logic [24:0] prod;
    logic [8:0]  q;
    logic [11:0] q9;
    logic [11:0] rem;
    logic [3:0]  r;
    logic [4:0]  r2;
    logic [4:0]  r2m;
    logic [3:0]  err;

    always_comb
    begin
        err[0] = ($signed(head.op) != OP_READ) && ($signed(head.op) != OP_WRITE);
        err[1] = head.req[15] || (head.req == 16'd0);
        err[2] = head.blk[15] || (head.blk == 16'd0) || (head.blk > {4'd0, block_count});
        err[3] = head.bytes[15] || (head.bytes > max_block_size);
    end

    // Divide by nine through the reciprocal; valid blocks keep b below 4096.
    assign b    = head.blk[11:0] - 12'd1;
    assign prod = {13'd0, b} * {12'd0, DIV9_RECIP};
    assign q    = prod[24:16];
    assign q9   = {q, 3'b000} + {3'b000, q};
    assign rem  = b - q9;
    assign r    = rem[3:0];
    assign r2   = {r, 1'b0};
    assign r2m  = r2 - 5'd9;

    always_comb
    begin
        res.err      = err;
        res.cylinder = '0;
        res.track    = 1'b0;
        res.sector   = '0;
        if (err == 4'd0)
        begin
            res.cylinder = q;
            res.track    = (r >= 4'd5);
            res.sector   = (r2 < 5'd9) ? r2[3:0] : r2m[3:0];
        end
    end

endmodule

// ===== hdl/disk_request_scheduler.sv =====
// Top level of the disk request scheduler: sorted request chain and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | mode, op_code, request_id, blk_num,
//          |           |                      | block_bytes, data_address
//  out     | output    | out_valid / out_stall | kind, motor_action, out_*, cylinder,
//          |           |                      | track, sector, error_flags
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// The chain of cells inserts or removes on the same clock edge that loads the
// result of the transaction into the output register.
// Throughput is one transaction per cycle while the output side keeps up.
// in_stall follows out_stall whenever the output register holds a result.
// Reset clears the pending count, idle count and motor state; slot contents are
// not cleared, since only slots below the pending count are ever read.
//
// Pending requests sit in a row of cells kept sorted by signed block number,
// oldest first among equal blocks. A submit drops into place with every larger
// entry shifting one cell down; a serve takes cell 0 and shifts the row up.
module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DRS_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic signed [7:0]      op_code,
    input  logic signed [15:0]     request_id,
    input  logic signed [15:0]     blk_num,
    input  logic signed [15:0]     block_bytes,
    input  logic [31:0]            data_address,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [1:0]             motor_action,
    output logic signed [15:0]     out_request_id,
    output logic signed [7:0]      out_op_code,
    output logic signed [15:0]     out_block,
    output logic signed [15:0]     out_bytes,
    output logic [31:0]            out_address,
    output logic [8:0]             cylinder,
    output logic                   track,
    output logic [3:0]             sector,
    output logic [3:0]             error_flags
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    logic [3:0]  idle_limit_reg;
    logic [11:0] block_count_reg;
    logic [15:0] max_block_size_reg;

    // Control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       idle_reg, idle_next;
    logic             motor_reg, motor_next;
    logic             out_valid_reg, out_valid_next;

    // Result register
    kind_t  kind_reg, kind_next;
    motor_t motor_act_reg, motor_act_next;
    entry_t res_entry_reg, res_entry_next;
    xlate_t res_x_reg, res_x_next;

    logic       in_fire;
    logic       out_fire;
    logic       full;
    logic       empty;
    logic       submit_ok;
    logic       serve_work;
    logic [3:0] idle_inc;

    entry_t     entry_new;
    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_gt    [QUEUE_DEPTH];
    logic       cell_occ   [QUEUE_DEPTH];
    cell_ctrl_t ctrl;
    xlate_t     head_x;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign submit_ok  = in_fire && !mode && !full && (op_code != 8'sd0);
    assign serve_work = in_fire && mode && !empty;
    assign idle_inc   = idle_reg + 4'd1;

    assign ctrl.insert = submit_ok;
    assign ctrl.remove = serve_work;

    assign entry_new.op    = op_code;
    assign entry_new.req   = request_id;
    assign entry_new.blk   = blk_num;
    assign entry_new.bytes = block_bytes;
    assign entry_new.addr  = data_address;

    // Row of cells; cell 0 holds the next request to serve whenever any are pending
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t e_prev;
            entry_t e_next;
            logic   o_prev;
            logic   g_prev;

            assign cell_occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign e_prev = entry_new;
                assign o_prev = 1'b1;
                assign g_prev = 1'b0;
            end
            else
            begin : g_mid
                assign e_prev = cell_entry[gi-1];
                assign o_prev = cell_occ[gi-1];
                assign g_prev = cell_gt[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign e_next = cell_entry[gi];
            end
            else
            begin : g_inner
                assign e_next = cell_entry[gi+1];
            end

            drs_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .entry_new  (entry_new),
                .entry_prev (e_prev),
                .entry_next (e_next),
                .occ_self   (cell_occ[gi]),
                .occ_prev   (o_prev),
                .gt_prev    (g_prev),
                .entry      (cell_entry[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    drs_xlate u_xlate (
        .head           (cell_entry[0]),
        .block_count    (block_count_reg),
        .max_block_size (max_block_size_reg),
        .res            (head_x)
    );

    // Next state: pending count, idle count, motor
    always_comb
    begin
        count_next = count_reg;
        idle_next  = idle_reg;
        motor_next = motor_reg;
        if (submit_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (serve_work)
        begin
            count_next = count_reg - CNT_W'(1);
            if (!motor_reg)
            begin
                motor_next = 1'b1;
                idle_next  = 4'd0;
            end
        end
        else if (in_fire && mode)
        begin
            idle_next = idle_inc;
            if (idle_inc == idle_limit_reg)
            begin
                idle_next  = 4'd0;
                motor_next = 1'b0;
            end
        end
    end

    // Result for the accepted transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        motor_act_next = motor_act_reg;
        res_entry_next = res_entry_reg;
        res_x_next     = res_x_reg;
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            motor_act_next = MOTOR_NONE;
            res_entry_next = '0;
            res_x_next     = '0;
            if (!mode)
            begin
                kind_next = submit_ok ? KIND_QUEUED : KIND_NOT_QUEUED;
            end
            else if (empty)
            begin
                kind_next = KIND_IDLE;
                if ((idle_inc == idle_limit_reg) && motor_reg)
                begin
                    motor_act_next = MOTOR_STOP;
                end
            end
            else
            begin
                kind_next      = (head_x.err == 4'd0) ? KIND_SERVED : KIND_REJECTED;
                motor_act_next = motor_reg ? MOTOR_NONE : MOTOR_START;
                res_entry_next = cell_entry[0];
                res_x_next     = head_x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg     <= IDLE_LIMIT_RST;
            block_count_reg    <= BLOCK_COUNT_RST;
            max_block_size_reg <= MAX_BLOCK_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDLE_LIMIT:     idle_limit_reg     <= cfg_data[3:0];
                CFG_BLOCK_COUNT:    block_count_reg    <= cfg_data[11:0];
                CFG_MAX_BLOCK_SIZE: max_block_size_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idle_reg      <= 4'd0;
            motor_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            motor_reg     <= motor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the result register needs no reset
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        motor_act_reg <= motor_act_next;
        res_entry_reg <= res_entry_next;
        res_x_reg     <= res_x_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign motor_action   = motor_act_reg;
    assign out_request_id = res_entry_reg.req;
    assign out_op_code    = res_entry_reg.op;
    assign out_block      = res_entry_reg.blk;
    assign out_bytes      = res_entry_reg.bytes;
    assign out_address    = res_entry_reg.addr;
    assign cylinder       = res_x_reg.cylinder;
    assign track          = res_x_reg.track;
    assign sector         = res_x_reg.sector;
    assign error_flags    = res_x_reg.err;

    // Pending count never runs past the row of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count exceeds queue depth");

    // A queued submit grows the table by exactly one
    a_submit_grows: assert property (@(posedge clk) disable iff (!rst_n)
        submit_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queued submit did not grow the table");

    // Motor start comes only with a served or rejected request
    a_start_on_work: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && motor_act_reg == MOTOR_START) |->
            (kind_reg == KIND_SERVED || kind_reg == KIND_REJECTED))
        else $error("motor start without work");

    // Served results carry no error bits
    a_served_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_SERVED) |-> res_x_reg.err == 4'd0)
        else $error("served result with error bits");

endmodule
